### design/present_locked_retrace_pacer_core_macros.svh
// Assertion macros shared by the pacer checker.
`ifndef PRESENT_LOCKED_RETRACE_PACER_CORE_MACROS_SVH
`define PRESENT_LOCKED_RETRACE_PACER_CORE_MACROS_SVH

// Implication checked outside reset.
`define PLRP_ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pacer check failed");

// Implication checked at every edge, reset included.
`define PLRP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pacer check failed");

`endif

### design/plrp_pkg.sv
// Shared types and constants of the present-locked retrace pacer.
package plrp_pkg;

  localparam int REG_BITS          = 20;
  localparam int FB_BITS           = 32;
  localparam int AVG_BITS          = 28;
  localparam int FRAC_BITS         = 6;
  localparam int CFG_INDEX_BITS    = 4;
  localparam int TIME_BITS_DEFAULT = 48;
  localparam int ADDR_BITS_DEFAULT = 32;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD    = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRACE     = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESYNC    = 4'd3;

  // register reset values
  localparam logic [REG_BITS-1:0] PERIOD_RESET    = 20'd16667;
  localparam logic [REG_BITS-1:0] TOLERANCE_RESET = 20'd2000;
  localparam logic [REG_BITS-1:0] GRACE_RESET     = 20'd6667;
  localparam logic [REG_BITS-1:0] RESYNC_RESET    = 20'd100000;

  // action codes
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_PRESENT = 2'd1;
  localparam logic [1:0] ACT_SWAP    = 2'd2;

  // lock divisor codes
  localparam logic [1:0] DIV_NONE = 2'd0;
  localparam logic [1:0] DIV_ONE  = 2'd1;
  localparam logic [1:0] DIV_TWO  = 2'd2;

  typedef struct packed {
    logic [REG_BITS-1:0] period;
    logic [REG_BITS-1:0] tolerance;
    logic [REG_BITS-1:0] grace;
    logic [REG_BITS-1:0] resync;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [FB_BITS-1:0] framebuffer;
  } item_t;

  typedef struct packed {
    logic               retrace;
    logic [FB_BITS-1:0] current_fb;
    logic [1:0]         divisor;
  } result_t;

endpackage

### design/plrp_cfg_regs.sv
// Configuration register file of the pacer.
module plrp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [plrp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [plrp_pkg::REG_BITS-1:0]       cfg_wdata,
  output plrp_pkg::cfg_t                      cfg
);
  import plrp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period    <= PERIOD_RESET;
      cfg.tolerance <= TOLERANCE_RESET;
      cfg.grace     <= GRACE_RESET;
      cfg.resync    <= RESYNC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD:    cfg.period    <= cfg_wdata;
        REG_TOLERANCE: cfg.tolerance <= cfg_wdata;
        REG_GRACE:     cfg.grace     <= cfg_wdata;
        REG_RESYNC:    cfg.resync    <= cfg_wdata;
        default: ; // unmapped index: dropped
      endcase
    end
  end

endmodule

### design/plrp_engine.sv
// Pacer state and the combinational update applied per item.
module plrp_engine #(
  parameter int TIME_BITS = plrp_pkg::TIME_BITS_DEFAULT,
  parameter int ADDR_BITS = plrp_pkg::ADDR_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  plrp_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  plrp_pkg::item_t   item,
  output plrp_pkg::result_t result
);
  import plrp_pkg::*;

  localparam int IV_BITS = REG_BITS + 2;          // four periods
  localparam logic [31:0] RECIP_FIVE = 32'hCCCCCCCD; // ceil(2^34 / 5)

  function automatic logic [1:0] classify(input logic [AVG_BITS-1:0] avg,
                                          input logic [REG_BITS-1:0] p,
                                          input logic [REG_BITS-1:0] t);
    logic signed [AVG_BITS+1:0] a_s;
    logic signed [AVG_BITS+1:0] p_s;
    logic signed [AVG_BITS+1:0] t_s;
    logic signed [AVG_BITS+1:0] lo1;
    logic signed [AVG_BITS+1:0] hi1;
    logic signed [AVG_BITS+1:0] lo2;
    logic signed [AVG_BITS+1:0] hi2;
    a_s = signed'({2'b00, avg});
    p_s = signed'({{(AVG_BITS+2-REG_BITS){1'b0}}, p});
    t_s = signed'({{(AVG_BITS+2-REG_BITS){1'b0}}, t});
    lo1 = (p_s - t_s) <<< FRAC_BITS;
    hi1 = (p_s + t_s) <<< FRAC_BITS;
    lo2 = lo1 <<< 1;
    hi2 = hi1 <<< 1;
    if (avg == '0)
      return DIV_NONE;
    else if (a_s > lo1 && a_s < hi1)
      return DIV_ONE;
    else if (a_s > lo2 && a_s < hi2)
      return DIV_TWO;
    else
      return DIV_NONE;
  endfunction

  // state
  logic [TIME_BITS-1:0] time_now,     time_now_next;
  logic [TIME_BITS-1:0] deadline,     deadline_next;
  logic [TIME_BITS-1:0] last_retrace, last_retrace_next;
  logic [TIME_BITS-1:0] last_present, last_present_next;
  logic                 present_seen, present_seen_next;
  logic [AVG_BITS-1:0]  avg,          avg_next;
  logic [1:0]           divisor,      divisor_next;
  logic                 half_pending, half_pending_next;
  logic [ADDR_BITS-1:0] next_fb,      next_fb_next;
  logic [ADDR_BITS-1:0] current_fb,   current_fb_next;

  // datapath
  logic [TIME_BITS-1:0] period_t, grace_t, resync_t, half_period_t, four_period_t;
  logic [TIME_BITS-1:0] time_inc, dl_gap, dl_step, dl_lag;
  logic [TIME_BITS-1:0] iv, since_retrace;
  logic                 iv_big;
  logic [AVG_BITS-1:0]  iv_fix, avg_upd, avg_quot;
  logic [31:0]          avg_sum;
  logic [63:0]          avg_prod;
  logic [1:0]           div_new;
  logic                 fired;
  logic [ADDR_BITS+FB_BITS-1:0] fb_wide, cur_wide;

  assign period_t      = {{(TIME_BITS-REG_BITS){1'b0}}, cfg.period};
  assign grace_t       = {{(TIME_BITS-REG_BITS){1'b0}}, cfg.grace};
  assign resync_t      = {{(TIME_BITS-REG_BITS){1'b0}}, cfg.resync};
  assign half_period_t = {{(TIME_BITS-REG_BITS+1){1'b0}}, cfg.period[REG_BITS-1:1]};
  assign four_period_t = {{(TIME_BITS-IV_BITS){1'b0}}, cfg.period, 2'b00};

  // tick side
  assign time_inc = time_now + TIME_BITS'(1);
  assign dl_gap   = time_inc - deadline;
  assign dl_step  = deadline + period_t;
  assign dl_lag   = time_inc - dl_step;

  // present side: 0.8 old + 0.2 new, divide by five via reciprocal
  assign iv       = time_now - last_present;
  assign iv_big   = iv > four_period_t;
  assign iv_fix   = {iv[IV_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign avg_sum  = {2'b00, avg, 2'b00} + {4'b0000, iv_fix} + 32'd2;
  assign avg_prod = {32'd0, avg_sum} * {32'd0, RECIP_FIVE};
  assign avg_quot = avg_prod[34 +: AVG_BITS];

  always_comb begin
    if (!present_seen)
      avg_upd = avg;
    else if (iv_big)
      avg_upd = '0;
    else if (avg == '0)
      avg_upd = iv_fix;
    else
      avg_upd = avg_quot;
  end

  assign div_new       = classify(avg_upd, cfg.period, cfg.tolerance);
  assign since_retrace = time_now - last_retrace;

  assign fb_wide = {{ADDR_BITS{1'b0}}, item.framebuffer};

  always_comb begin
    time_now_next     = time_now;
    deadline_next     = deadline;
    last_retrace_next = last_retrace;
    last_present_next = last_present;
    present_seen_next = present_seen;
    avg_next          = avg;
    divisor_next      = divisor;
    half_pending_next = half_pending;
    next_fb_next      = next_fb;
    current_fb_next   = current_fb;
    fired             = 1'b0;
    unique case (item.action)
      ACT_TICK: begin
        time_now_next = time_inc;
        if (!dl_gap[TIME_BITS-1]) begin
          fired             = 1'b1;
          current_fb_next   = next_fb;
          last_retrace_next = time_inc;
          if (half_pending) begin
            half_pending_next = 1'b0;
            deadline_next     = time_inc + period_t + grace_t;
          end else if (!dl_lag[TIME_BITS-1] && dl_lag > resync_t) begin
            deadline_next = time_inc + period_t;
          end else begin
            deadline_next = dl_step;
          end
        end
      end
      ACT_PRESENT: begin
        avg_next          = avg_upd;
        last_present_next = time_now;
        present_seen_next = 1'b1;
        divisor_next      = div_new;
        if (div_new != DIV_NONE && since_retrace >= half_period_t) begin
          fired             = 1'b1;
          current_fb_next   = next_fb;
          last_retrace_next = time_now;
          half_pending_next = (div_new == DIV_TWO);
          deadline_next     = time_now + period_t +
                              ((div_new == DIV_TWO) ? '0 : grace_t);
        end
      end
      ACT_SWAP: begin
        next_fb_next = fb_wide[ADDR_BITS-1:0];
      end
      default: ; // unused code: no change
    endcase
  end

  assign cur_wide          = {{FB_BITS{1'b0}}, current_fb_next};
  assign result.retrace    = fired;
  assign result.current_fb = cur_wide[FB_BITS-1:0];
  assign result.divisor    = divisor_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now     <= '0;
      deadline     <= {{(TIME_BITS-REG_BITS){1'b0}}, PERIOD_RESET};
      last_retrace <= '0;
      last_present <= '0;
      present_seen <= 1'b0;
      avg          <= '0;
      divisor      <= DIV_NONE;
      half_pending <= 1'b0;
      next_fb      <= '0;
      current_fb   <= '0;
    end else if (item_valid) begin
      time_now     <= time_now_next;
      deadline     <= deadline_next;
      last_retrace <= last_retrace_next;
      last_present <= last_present_next;
      present_seen <= present_seen_next;
      avg          <= avg_next;
      divisor      <= divisor_next;
      half_pending <= half_pending_next;
      next_fb      <= next_fb_next;
      current_fb   <= current_fb_next;
    end
  end

endmodule

### design/present_locked_retrace_pacer_core.sv
// Top level of the present-locked retrace pacer.
//
// Input channel (in_valid / in_stall, action, framebuffer): one transaction per
// event. A tick advances the microsecond counter, a present updates the frame
// interval average and lock state, a swap loads the next framebuffer.
// Output channel (out_valid / out_stall): exactly one result transaction per
// input transaction, in order: retrace flag, displayed framebuffer and lock
// divisor after the event.
// Path: input transaction to result transaction through the input register,
// then the engine update into the result register; out_valid rises when the
// input register moves on. Throughput: one transaction per cycle while
// out_stall is low; the engine applies every event in one combinational
// update, so back-to-back ticks are taken at full clock rate.
// Stall: the result register holds while out_stall is high; the input
// register can still take one more transaction, after which in_stall rises.
// Reset (rst, synchronous): empties both registers, loads register defaults
// and the initial deadline of one period. No clearing pass.
// Configuration: cfg_we writes cfg_index immediately; write only when idle.
module present_locked_retrace_pacer_core #(
  parameter int TIME_BITS = plrp_pkg::TIME_BITS_DEFAULT,
  parameter int ADDR_BITS = plrp_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [plrp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [plrp_pkg::REG_BITS-1:0]       cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [plrp_pkg::FB_BITS-1:0]        framebuffer,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                retrace,
  output logic [plrp_pkg::FB_BITS-1:0]        current_framebuffer,
  output logic [1:0]                          lock_divisor
);
  import plrp_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    in_take;
  logic    s1_move;   // stage-1 item enters the engine this cycle
  result_t eng_result;

  // Stage 1 moves whenever the result register is empty or being drained.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  plrp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.action      <= action;
      s1_item.framebuffer <= framebuffer;
    end
  end

  plrp_engine #(
    .TIME_BITS (TIME_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s1_move),
    .item       (s1_item),
    .result     (eng_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      retrace             <= eng_result.retrace;
      current_framebuffer <= eng_result.current_fb;
      lock_divisor        <= eng_result.divisor;
    end
  end

endmodule

### design/plrp_checker.sv
// Port-level checks of the pacer, bound to the top level.
`include "present_locked_retrace_pacer_core_macros.svh"

module plrp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         retrace,
  input logic [plrp_pkg::FB_BITS-1:0] current_framebuffer,
  input logic [1:0]                   lock_divisor
);
  import plrp_pkg::*;

  logic               out_take;
  logic               seen;
  logic [FB_BITS-1:0] last_fb;
  logic [FB_BITS+2:0] res_bits;
  logic               fb_same;

  assign out_take = out_valid && !out_stall;
  assign res_bits = {retrace, current_framebuffer, lock_divisor};
  assign fb_same  = (current_framebuffer == last_fb);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_take) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      last_fb <= current_framebuffer;
    end
  end

  // stalled result holds
  `PLRP_ASSERT_HOLDS(a_out_hold, clk, rst, (out_valid && out_stall |=> out_valid && $stable(res_bits)))
  // reset empties the output
  `PLRP_ASSERT_ALWAYS(a_rst_empty, clk, (rst |=> !out_valid))
  // displayed buffer only moves on a retrace
  `PLRP_ASSERT_HOLDS(a_fb_steady, clk, rst, (out_take && seen && !retrace |-> fb_same))
  // an empty result register never back-pressures the input
  `PLRP_ASSERT_HOLDS(a_no_stall_empty, clk, rst, (!out_valid |-> !in_stall))

endmodule

bind present_locked_retrace_pacer_core plrp_checker u_plrp_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .retrace             (retrace),
  .current_framebuffer (current_framebuffer),
  .lock_divisor        (lock_divisor)
);
